>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define QBF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qbf assertion failed");

// next-cycle implication
`define QBF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qbf assertion failed");

`endif

>>> rtl/qbf_pkg.sv
// ----------------------------------------------------------------------------
// qbf_pkg
// Types and constants of the quartic flat-bottom bond force engine.
// ----------------------------------------------------------------------------
`default_nettype none

package qbf_pkg;

   localparam int unsigned POS_W      = 32;
   localparam int unsigned IDX_W      = 20;
   localparam int unsigned DIFF_W     = 33;
   localparam int unsigned MAG_W      = 33;
   localparam int unsigned SQ_W       = 66;
   localparam int unsigned SQ_PAD_W   = 68;
   localparam int unsigned ROOT_W     = 34;
   localparam int unsigned REM_W      = 36;
   localparam int unsigned K_W        = 32;
   localparam int unsigned REST_W     = 24;
   localparam int unsigned PROD_W     = 168;
   localparam int unsigned QUO_W      = 47;
   localparam int unsigned ENERGY_W   = 47;
   localparam int unsigned FORCE_W    = 48;
   localparam int unsigned CSR_IDX_W  = 8;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CNT_W      = 7;

   localparam logic [K_W-1:0]    K_RESET    = 32'd2000000;
   localparam logic [REST_W-1:0] REST_RESET = 24'd209715;

   localparam logic [CSR_IDX_W-1:0] CSR_FORCE_CONSTANT = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REST_LENGTH    = 8'd1;

   localparam logic [2:0] MUL_KD  = 3'd0;
   localparam logic [2:0] MUL_KD2 = 3'd1;
   localparam logic [2:0] MUL_KD3 = 3'd2;
   localparam logic [2:0] MUL_KD4 = 3'd3;
   localparam logic [2:0] MUL_MAG = 3'd4;

   localparam logic [QUO_W-1:0] MAG_LIMIT = '1;

   typedef struct packed {
      logic [SQ_W-1:0]         sum_sq;
      logic [2:0][MAG_W-1:0]   mag;
      logic [2:0]              pos;
      logic [IDX_W-1:0]        first_index;
      logic [IDX_W-1:0]        second_index;
   } qbf_item_type;

   typedef struct packed {
      logic         valid;
      qbf_item_type item;
   } qbf_push_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SQRT,
      BK_TEST,
      BK_MUL,
      BK_DIV,
      BK_DONE
   } qbf_back_state_type;

endpackage

`default_nettype wire

>>> rtl/qbf_front.sv
// ----------------------------------------------------------------------------
// qbf_front
// Request intake: separation vector, per-axis magnitudes and squares, and
// the squared length, pushed to the work queue.
// ----------------------------------------------------------------------------
`default_nettype none

module qbf_front
   import qbf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic signed [POS_W-1:0] ri_x,
   input  logic signed [POS_W-1:0] ri_y,
   input  logic signed [POS_W-1:0] ri_z,
   input  logic signed [POS_W-1:0] rj_x,
   input  logic signed [POS_W-1:0] rj_y,
   input  logic signed [POS_W-1:0] rj_z,
   input  logic [IDX_W-1:0]        first_index,
   input  logic [IDX_W-1:0]        second_index,
   output qbf_push_type            push,
   output logic [1:0]              in_flight
);

   logic                v1_ff, v1_in, v2_ff, v2_in;
   logic [DIFF_W-1:0]   dx1_ff [3];
   logic [DIFF_W-1:0]   dx1_in [3];
   logic [IDX_W-1:0]    fi1_ff, si1_ff, fi2_ff, si2_ff;
   logic [MAG_W-1:0]    mag2_ff [3];
   logic [MAG_W-1:0]    mag2_in [3];
   logic [SQ_W-1:0]     sq2_ff [3];
   logic [SQ_W-1:0]     sq2_in [3];
   logic [2:0]          pos2_ff, pos2_in;
   logic [POS_W-1:0]    ri [3];
   logic [POS_W-1:0]    rj [3];

   always_comb begin
      ri[0] = ri_x;
      ri[1] = ri_y;
      ri[2] = ri_z;
      rj[0] = rj_x;
      rj[1] = rj_y;
      rj[2] = rj_z;
      v1_in = accept;
      v2_in = v1_ff;
      for (int k = 0; k < 3; k++) begin
         dx1_in[k]  = {ri[k][POS_W-1], ri[k]} - {rj[k][POS_W-1], rj[k]};
         mag2_in[k] = dx1_ff[k][DIFF_W-1] ? (~dx1_ff[k] + 1'b1) : dx1_ff[k];
         sq2_in[k]  = mag2_in[k] * mag2_in[k];
         pos2_in[k] = !dx1_ff[k][DIFF_W-1] && (dx1_ff[k] != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
      for (int k = 0; k < 3; k++) begin
         dx1_ff[k]  <= dx1_in[k];
         mag2_ff[k] <= mag2_in[k];
         sq2_ff[k]  <= sq2_in[k];
      end
      pos2_ff <= pos2_in;
      fi1_ff  <= first_index;
      si1_ff  <= second_index;
      fi2_ff  <= fi1_ff;
      si2_ff  <= si1_ff;
   end

   always_comb begin
      push.valid             = v2_ff;
      push.item.sum_sq       = sq2_ff[0] + sq2_ff[1] + sq2_ff[2];
      push.item.mag[0]       = mag2_ff[0];
      push.item.mag[1]       = mag2_ff[1];
      push.item.mag[2]       = mag2_ff[2];
      push.item.pos          = pos2_ff;
      push.item.first_index  = fi2_ff;
      push.item.second_index = si2_ff;
   end

   assign in_flight = {1'b0, v1_ff} + {1'b0, v2_ff};

endmodule

`default_nettype wire

>>> rtl/qbf_queue.sv
// ----------------------------------------------------------------------------
// qbf_queue
// Short FIFO between the intake and the force sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module qbf_queue
   import qbf_pkg::*;
#(
   parameter int unsigned DEPTH = 4
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  qbf_push_type                 push,
   input  logic                         pop,
   output qbf_item_type                 head,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_Q = $clog2(DEPTH + 1);

   qbf_item_type       mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_Q-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority case ({push.valid, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.item;
      end
   end

   assign head  = mem_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign count = count_ff;

endmodule

`default_nettype wire

>>> rtl/qbf_back.sv
// ----------------------------------------------------------------------------
// qbf_back
// Force sequencer: digit-serial square root, restoring divider for the three
// force axes, and shift-add multiplier shared over energy and the force axes.
// ----------------------------------------------------------------------------
`default_nettype none

module qbf_back
   import qbf_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  qbf_item_type              head,
   input  logic                      empty,
   input  logic [K_W-1:0]            force_constant,
   input  logic [REST_W-1:0]         rest_length,
   output logic                      pop,
   output logic                      rsp_valid,
   output logic [ENERGY_W-1:0]       rsp_bond_energy,
   output logic signed [FORCE_W-1:0] rsp_force_x,
   output logic signed [FORCE_W-1:0] rsp_force_y,
   output logic signed [FORCE_W-1:0] rsp_force_z,
   output logic [IDX_W-1:0]          rsp_out_first_index,
   output logic [IDX_W-1:0]          rsp_out_second_index,
   output logic                      rsp_stretched
);

   qbf_back_state_type state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   qbf_item_type         item_ff, item_in;
   logic [SQ_PAD_W-1:0]  s_ff, s_in;
   logic [ROOT_W-1:0]    root_ff, root_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [ROOT_W-1:0]    d_ff, d_in;
   logic [PROD_W-1:0]    mcand_ff, mcand_in;
   logic [ROOT_W-1:0]    mplier_ff, mplier_in;
   logic [PROD_W-1:0]    acc_ff, acc_in;
   logic [PROD_W-1:0]    p3_ff, p3_in;
   logic [2:0]           mstep_ff, mstep_in;
   logic [1:0]           axis_ff, axis_in;
   logic [QUO_W-1:0]     quo_ff, quo_in;
   logic [ENERGY_W-1:0]  energy_ff, energy_in;
   logic [FORCE_W-1:0]   force_ff [3];
   logic [FORCE_W-1:0]   force_in [3];
   logic                 stretched_ff, stretched_in;

   logic [REM_W+1:0]     sq_cand, sq_trial, sq_diff;
   logic                 sq_ge;
   logic [PROD_W-1:0]    acc_step;
   logic [ROOT_W:0]      dv_cand, dv_diff;
   logic                 dv_ge;
   logic [QUO_W-1:0]     quo_step;
   logic                 axis_done;
   logic [QUO_W-1:0]     axis_mag;
   logic [1:0]           axis_next;

   function automatic logic [FORCE_W-1:0] signed_force(input logic [QUO_W-1:0] mag,
                                                        input logic pos);
      logic [FORCE_W-1:0] ext;
      ext = {1'b0, mag};
      return pos ? (~ext + 1'b1) : ext;
   endfunction

   always_comb begin
      sq_cand  = {rem_ff, s_ff[SQ_PAD_W-1 -: 2]};
      sq_trial = {2'b00, root_ff, 2'b01};
      sq_ge    = (sq_cand >= sq_trial);
      sq_diff  = sq_cand - sq_trial;
      acc_step = {acc_ff[PROD_W-2:0], 1'b0} + (mplier_ff[ROOT_W-1] ? mcand_ff : '0);
      dv_cand  = {rem_ff[ROOT_W-1:0], quo_ff[QUO_W-1]};
      dv_ge    = (dv_cand >= {1'b0, root_ff});
      dv_diff  = dv_cand - {1'b0, root_ff};
      quo_step = {quo_ff[QUO_W-2:0], dv_ge};
      axis_next = axis_ff + 2'd1;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      item_in      = item_ff;
      s_in         = s_ff;
      root_in      = root_ff;
      rem_in       = rem_ff;
      d_in         = d_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      acc_in       = acc_ff;
      p3_in        = p3_ff;
      mstep_in     = mstep_ff;
      axis_in      = axis_ff;
      quo_in       = quo_ff;
      energy_in    = energy_ff;
      stretched_in = stretched_ff;
      for (int k = 0; k < 3; k++) begin
         force_in[k] = force_ff[k];
      end
      pop       = 1'b0;
      axis_done = 1'b0;
      axis_mag  = '0;

      unique case (state_ff)
         BK_IDLE, BK_DONE: begin
            if (!empty) begin
               pop      = 1'b1;
               item_in  = head;
               s_in     = {2'b00, head.sum_sq};
               root_in  = '0;
               rem_in   = '0;
               cnt_in   = CNT_W'(ROOT_W - 1);
               state_in = BK_SQRT;
            end else begin
               state_in = BK_IDLE;
            end
         end
         BK_SQRT: begin
            s_in    = {s_ff[SQ_PAD_W-3:0], 2'b00};
            rem_in  = sq_ge ? sq_diff[REM_W-1:0] : sq_cand[REM_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], sq_ge};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = BK_TEST;
            end
         end
         BK_TEST: begin
            if (root_ff <= {{(ROOT_W-REST_W){1'b0}}, rest_length}) begin
               energy_in    = '0;
               stretched_in = 1'b0;
               for (int k = 0; k < 3; k++) begin
                  force_in[k] = '0;
               end
               state_in = BK_DONE;
            end else begin
               stretched_in = 1'b1;
               d_in         = root_ff - {{(ROOT_W-REST_W){1'b0}}, rest_length};
               mplier_in    = root_ff - {{(ROOT_W-REST_W){1'b0}}, rest_length};
               mcand_in     = {{(PROD_W-K_W){1'b0}}, force_constant};
               acc_in       = '0;
               mstep_in     = MUL_KD;
               cnt_in       = CNT_W'(ROOT_W - 1);
               state_in     = BK_MUL;
            end
         end
         BK_MUL: begin
            if (cnt_ff != '0) begin
               acc_in    = acc_step;
               mplier_in = {mplier_ff[ROOT_W-2:0], 1'b0};
               cnt_in    = cnt_ff - 1'b1;
            end else begin
               acc_in = '0;
               cnt_in = CNT_W'(ROOT_W - 1);
               unique case (mstep_ff)
                  MUL_KD, MUL_KD2, MUL_KD3: begin
                     mcand_in  = acc_step;
                     mplier_in = d_ff;
                     if (mstep_ff == MUL_KD3) begin
                        p3_in    = acc_step;
                        mstep_in = MUL_KD4;
                     end else if (mstep_ff == MUL_KD2) begin
                        mstep_in = MUL_KD3;
                     end else begin
                        mstep_in = MUL_KD2;
                     end
                  end
                  MUL_KD4: begin
                     energy_in = (|acc_step[PROD_W-1:104]) ? MAG_LIMIT : acc_step[103:57];
                     axis_in   = 2'd0;
                     mcand_in  = p3_ff;
                     mplier_in = {1'b0, item_ff.mag[0]};
                     mstep_in  = MUL_MAG;
                  end
                  MUL_MAG: begin
                     if (acc_step[PROD_W-1:82] >= {52'b0, root_ff}) begin
                        axis_done = 1'b1;
                        axis_mag  = MAG_LIMIT;
                     end else begin
                        rem_in   = {2'b00, acc_step[115:82]};
                        quo_in   = acc_step[81:35];
                        cnt_in   = CNT_W'(QUO_W - 1);
                        state_in = BK_DIV;
                     end
                  end
                  default: begin
                     state_in = BK_IDLE;
                  end
               endcase
            end
         end
         BK_DIV: begin
            rem_in = {1'b0, (dv_ge ? dv_diff : dv_cand)};
            quo_in = quo_step;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               axis_done = 1'b1;
               axis_mag  = quo_step;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      if (axis_done) begin
         force_in[axis_ff] = signed_force(axis_mag, item_ff.pos[axis_ff]);
         if (axis_ff == 2'd2) begin
            state_in = BK_DONE;
         end else begin
            axis_in   = axis_next;
            mcand_in  = p3_ff;
            mplier_in = {1'b0, item_ff.mag[axis_next]};
            acc_in    = '0;
            cnt_in    = CNT_W'(ROOT_W - 1);
            state_in  = BK_MUL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      item_ff      <= item_in;
      s_ff         <= s_in;
      root_ff      <= root_in;
      rem_ff       <= rem_in;
      d_ff         <= d_in;
      mcand_ff     <= mcand_in;
      mplier_ff    <= mplier_in;
      acc_ff       <= acc_in;
      p3_ff        <= p3_in;
      mstep_ff     <= mstep_in;
      axis_ff      <= axis_in;
      quo_ff       <= quo_in;
      energy_ff    <= energy_in;
      stretched_ff <= stretched_in;
      for (int k = 0; k < 3; k++) begin
         force_ff[k] <= force_in[k];
      end
   end

   assign rsp_valid            = (state_ff == BK_DONE);
   assign rsp_bond_energy      = energy_ff;
   assign rsp_force_x          = force_ff[0];
   assign rsp_force_y          = force_ff[1];
   assign rsp_force_z          = force_ff[2];
   assign rsp_out_first_index  = item_ff.first_index;
   assign rsp_out_second_index = item_ff.second_index;
   assign rsp_stretched        = stretched_ff;

endmodule

`default_nettype wire

>>> rtl/quartic_bond_force.sv
// Path: intake registers, queue wait, then the force sequencer (square root and
//   test; multiply and divide too when stretched), result strobed for 1 cycle.
// Throughput: one request per cycle into the queue while not busy; the serial
//   square root, shift-add multiplier and divider finish a request before the next.
// Reset: synchronous, active high; empties queue, idles sequencer, reloads K and
//   rest length. Results cannot be stalled by the receiver.
`default_nettype none

module quartic_bond_force
   import qbf_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [POS_W-1:0]      req_ri_x,
   input  logic signed [POS_W-1:0]      req_ri_y,
   input  logic signed [POS_W-1:0]      req_ri_z,
   input  logic signed [POS_W-1:0]      req_rj_x,
   input  logic signed [POS_W-1:0]      req_rj_y,
   input  logic signed [POS_W-1:0]      req_rj_z,
   input  logic [IDX_W-1:0]             req_first_index,
   input  logic [IDX_W-1:0]             req_second_index,
   output logic                         rsp_valid,
   output logic [ENERGY_W-1:0]          rsp_bond_energy,
   output logic signed [FORCE_W-1:0]    rsp_force_x,
   output logic signed [FORCE_W-1:0]    rsp_force_y,
   output logic signed [FORCE_W-1:0]    rsp_force_z,
   output logic [IDX_W-1:0]             rsp_out_first_index,
   output logic [IDX_W-1:0]             rsp_out_second_index,
   output logic                         rsp_stretched,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   localparam int unsigned CNT_Q = $clog2(QUEUE_DEPTH + 1);

   logic [K_W-1:0]     force_constant_ff;
   logic [REST_W-1:0]  rest_length_ff;
   qbf_push_type       push;
   qbf_item_type       head;
   logic               empty, pop, accept;
   logic [1:0]         in_flight;
   logic [CNT_Q-1:0]   count;
   logic [CNT_Q+1:0]   occupancy;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         force_constant_ff <= K_RESET;
         rest_length_ff    <= REST_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_FORCE_CONSTANT) begin
            force_constant_ff <= csr_wdata[K_W-1:0];
         end else if (csr_index == CSR_REST_LENGTH) begin
            rest_length_ff <= csr_wdata[REST_W-1:0];
         end
      end
   end

   assign occupancy = {2'b00, count} + {{CNT_Q{1'b0}}, in_flight};
   assign busy      = (occupancy >= (CNT_Q+2)'(QUEUE_DEPTH));
   assign accept    = start && !busy;

   qbf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .ri_x         (req_ri_x),
      .ri_y         (req_ri_y),
      .ri_z         (req_ri_z),
      .rj_x         (req_rj_x),
      .rj_y         (req_rj_y),
      .rj_z         (req_rj_z),
      .first_index  (req_first_index),
      .second_index (req_second_index),
      .push         (push),
      .in_flight    (in_flight)
   );

   qbf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .empty (empty),
      .count (count)
   );

   qbf_back u_back (
      .clock                (clock),
      .reset                (reset),
      .head                 (head),
      .empty                (empty),
      .force_constant       (force_constant_ff),
      .rest_length          (rest_length_ff),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_bond_energy      (rsp_bond_energy),
      .rsp_force_x          (rsp_force_x),
      .rsp_force_y          (rsp_force_y),
      .rsp_force_z          (rsp_force_z),
      .rsp_out_first_index  (rsp_out_first_index),
      .rsp_out_second_index (rsp_out_second_index),
      .rsp_stretched        (rsp_stretched)
   );

endmodule

`default_nettype wire

>>> rtl/qbf_checker.sv
// ----------------------------------------------------------------------------
// qbf_checker
// Port-level checks on the bond force engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module qbf_checker (
   input wire        clock,
   input wire        reset,
   input wire        busy,
   input wire        rsp_valid,
   input wire        rsp_stretched,
   input wire [46:0] rsp_bond_energy,
   input wire [47:0] rsp_force_x,
   input wire [47:0] rsp_force_y,
   input wire [47:0] rsp_force_z
);

   `QBF_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !busy && !rsp_valid)
   `QBF_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)
   `QBF_ASSERT_IMPLY(a_flat_zero, clock, reset, rsp_valid && !rsp_stretched, (rsp_bond_energy == 47'd0) && (rsp_force_x == 48'd0) && (rsp_force_y == 48'd0) && (rsp_force_z == 48'd0))
   `QBF_ASSERT_IMPLY(a_sym_saturate, clock, reset, rsp_valid, (rsp_force_x != {1'b1, 47'd0}) && (rsp_force_y != {1'b1, 47'd0}) && (rsp_force_z != {1'b1, 47'd0}))

endmodule

bind quartic_bond_force qbf_checker u_checker (.*);

`default_nettype wire
